### src/prc_pkg.sv
// Shared types, widths and codes of the polyline cell rasterizer.
`default_nettype none
package prc_pkg;

	localparam int COORD_INT_BITS  = 14;
	localparam int COORD_FRAC_BITS = 8;
	localparam int SLOPE_FRAC_BITS = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam int VERT_W   = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int DW       = VERT_W + 1;
	localparam int CW       = DW - COORD_FRAC_BITS + 1;
	localparam int CELL_W   = 14;
	localparam int GRID_W   = 13;
	localparam int ONE_F    = 1 << COORD_FRAC_BITS;
	localparam int ONE_S    = 1 << SLOPE_FRAC_BITS;
	localparam int SH       = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
	localparam int QW       = SLOPE_FRAC_BITS + 1;
	localparam int SLW      = SLOPE_FRAC_BITS + 2;
	localparam int ERR_W    = SLOPE_FRAC_BITS + 4;
	localparam int MPW      = DW + SH + 3;
	localparam int STEPS_W  = DW - COORD_FRAC_BITS;
	localparam int REM_W    = DW + 1;
	localparam int CNT_W    = $clog2(QW);
	localparam int DIST_W   = COORD_FRAC_BITS + 1;
	localparam int PROD_W   = QW + DIST_W;
	localparam int S_DATA_W = ((2 * VERT_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((2 * CELL_W + 7) / 8) * 8;
	localparam int IDX_W    = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [IDX_W-1:0] REG_LINE_MODE    = 2'd0;
	localparam logic [IDX_W-1:0] REG_GRID_COLUMNS = 2'd1;
	localparam logic [IDX_W-1:0] REG_GRID_ROWS    = 2'd2;

	localparam logic MODE_THIN = 1'b0;

	typedef enum logic [1:0] {
		K_STEP,
		K_STORE,
		K_OPEN
	} prc_kind_t;

	typedef struct packed {
		prc_kind_t                 kind;
		logic signed [VERT_W-1:0]  ax;
		logic signed [VERT_W-1:0]  ay;
		logic signed [VERT_W-1:0]  bx;
		logic signed [VERT_W-1:0]  by;
	} prc_cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DDA,
		PH_PRE,
		PH_MAJOR,
		PH_INNER,
		PH_FIX,
		PH_LAST
	} prc_phase_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ADV,
		B_DIV,
		B_FIN,
		B_ERR
	} prc_bstate_t;

endpackage
`default_nettype wire

### src/polyline_cell_rasterizer_unit.sv
// Top level of the polyline cell rasterizer: config registers, front, queue, back.
// A step request of a thin walk or of a cell-emitting walk step is written straight into the result register.
// A step that crosses walk phases (at most two phase changes) runs further sequencer passes in B_ADV first.
// A segment-opening load runs the slope divider (1 bit/cycle), then B_FIN, and B_ERR as well when thick.
// Results leave through one output register; a two-entry queue decouples input and walk.
// Reset is asynchronous, active low: walk idle, no previous vertex, line_mode 1, grid 4096 x 4096.
`default_nettype none
module polyline_cell_rasterizer_unit #(
	parameter int FIFO_DEPTH = prc_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [prc_pkg::S_DATA_W-1:0]  s_tdata,  // vertex_x, vertex_y
	input  wire logic [1:0]                    s_tuser,  // opcode, part_start
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [prc_pkg::M_DATA_W-1:0]       m_tdata,  // cell_x, cell_y
	output logic [1:0]                         m_tuser,  // cell_valid, in_grid
	output logic                               m_tlast,  // segment_end
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [prc_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [prc_pkg::GRID_W-1:0]    cfg_data
);
	import prc_pkg::*;

	logic              line_mode_q;
	logic [GRID_W-1:0] grid_columns_q;
	logic [GRID_W-1:0] grid_rows_q;
	logic              push, full, pop, not_empty;
	prc_cmd_t          push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q    <= 1'b1;
			grid_columns_q <= GRID_W'(4096);
			grid_rows_q    <= GRID_W'(4096);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_MODE:    line_mode_q    <= cfg_data[0];
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data;
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	prc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	prc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.not_empty (not_empty)
	);

	prc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (not_empty),
		.cmd          (pop_data),
		.cmd_pop      (pop),
		.line_mode    (line_mode_q),
		.grid_columns (grid_columns_q),
		.grid_rows    (grid_rows_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule
`default_nettype wire

### src/prc_fifo.sv
// Short command queue between the front and the back of the rasterizer.
`default_nettype none
module prc_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire prc_pkg::prc_cmd_t push_data,
	input  wire logic              pop,
	output prc_pkg::prc_cmd_t      pop_data,
	output logic                   full,
	output logic                   not_empty
);
	import prc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	prc_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [NW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (cnt_q == NW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### src/prc_front.sv
// Input side: accept requests, keep the previous vertex, classify each request.
`default_nettype none
module prc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [prc_pkg::S_DATA_W-1:0]  s_tdata,  // vertex_x, vertex_y
	input  wire logic [1:0]                    s_tuser,  // opcode, part_start
	output logic                               push,
	output prc_pkg::prc_cmd_t                  push_data,
	input  wire logic                          full
);
	import prc_pkg::*;

	logic signed [VERT_W-1:0] prev_x_q;
	logic signed [VERT_W-1:0] prev_y_q;
	logic                     have_prev_q;
	logic                     accept;
	logic signed [VERT_W-1:0] vx;
	logic signed [VERT_W-1:0] vy;

	assign s_tready = !full;
	assign accept   = s_tvalid && !full;
	assign push     = accept;
	assign vx       = s_tdata[VERT_W-1:0];
	assign vy       = s_tdata[2*VERT_W-1:VERT_W];

	always_comb begin
		push_data.ax = prev_x_q;
		push_data.ay = prev_y_q;
		push_data.bx = vx;
		push_data.by = vy;
		if (s_tuser[0] == OP_STEP) begin
			push_data.kind = K_STEP;
		end else if (s_tuser[1] || !have_prev_q) begin
			push_data.kind = K_STORE;
		end else begin
			push_data.kind = K_OPEN;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser[0] == OP_LOAD) begin
			prev_x_q <= vx;
			prev_y_q <= vy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept && s_tuser[0] == OP_LOAD) begin
			have_prev_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

### src/prc_back.sv
// Back side: segment setup with iterative slope divider, cell walk, result register.
`default_nettype none
module prc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	input  wire prc_pkg::prc_cmd_t             cmd,
	output logic                               cmd_pop,
	input  wire logic                          line_mode,
	input  wire logic [prc_pkg::GRID_W-1:0]    grid_columns,
	input  wire logic [prc_pkg::GRID_W-1:0]    grid_rows,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [prc_pkg::M_DATA_W-1:0]       m_tdata,  // cell_x, cell_y
	output logic [1:0]                         m_tuser,  // cell_valid, in_grid
	output logic                               m_tlast   // segment_end
);
	import prc_pkg::*;

	prc_bstate_t state_q, state_nx;
	prc_phase_t  phase_q;

	logic signed [CW-1:0]     cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [MPW-1:0]    mp_q;
	logic [ERR_W-1:0]         err_q;
	logic signed [SLW-1:0]    slope_q;
	logic [STEPS_W-1:0]       steps_q;
	logic [2:0]               sgn_q;
	logic                     mode_q;
	logic                     dn_neg_q;
	logic [DW-1:0]            am_q;
	logic signed [DW-1:0]     start_n_q;
	logic [COORD_FRAC_BITS-1:0] fm_q, fn_q;
	logic [REM_W-1:0]         rem_q;
	logic [QW-1:0]            quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [PROD_W-1:0]        prod_q;

	logic                     ov_q;
	logic signed [CW-1:0]     ox_q, oy_q;
	logic                     ovalid_q, ogrid_q, oend_q;

	// segment setup
	logic signed [DW-1:0] sax, say, sbx, sby, sdx, sdy, sdm, sdn, s_start_m, s_start_n;
	logic [DW-1:0]        adx, ady, s_am, s_an;
	logic signed [CW-1:0] s_cx, s_cy, s_ex, s_ey;
	logic                 s_ymaj, s_sm_neg, s_sn_neg, s_degen;

	always_comb begin
		sax = {cmd.ax[VERT_W-1], cmd.ax} + DW'(ONE_F / 2);
		say = {cmd.ay[VERT_W-1], cmd.ay} + DW'(ONE_F / 2);
		sbx = {cmd.bx[VERT_W-1], cmd.bx} + DW'(ONE_F / 2);
		sby = {cmd.by[VERT_W-1], cmd.by} + DW'(ONE_F / 2);
		s_cx = {sax[DW-1], sax[DW-1:COORD_FRAC_BITS]};
		s_cy = {say[DW-1], say[DW-1:COORD_FRAC_BITS]};
		s_ex = {sbx[DW-1], sbx[DW-1:COORD_FRAC_BITS]};
		s_ey = {sby[DW-1], sby[DW-1:COORD_FRAC_BITS]};
		s_degen = (s_cx == s_ex) && (s_cy == s_ey);
		sdx = {cmd.bx[VERT_W-1], cmd.bx} - {cmd.ax[VERT_W-1], cmd.ax};
		sdy = {cmd.by[VERT_W-1], cmd.by} - {cmd.ay[VERT_W-1], cmd.ay};
		adx = sdx[DW-1] ? DW'(-sdx) : DW'(sdx);
		ady = sdy[DW-1] ? DW'(-sdy) : DW'(sdy);
		s_ymaj = !(adx > ady);
		sdm = s_ymaj ? sdy : sdx;
		sdn = s_ymaj ? sdx : sdy;
		s_am = s_ymaj ? ady : adx;
		s_an = s_ymaj ? adx : ady;
		s_start_m = s_ymaj ? say : sax;
		s_start_n = s_ymaj ? sax : say;
		s_sm_neg = sdm[DW-1];
		s_sn_neg = !(sdn > 0);
	end

	// one pass of the walk sequencer
	logic                 ymaj, sm_neg, sn_neg;
	logic signed [CW-1:0] mj, mn, mj_end, mn_end, nx_mj, nx_mn, nx_cx, nx_cy;
	logic signed [CW-1:0] sm_step, sn_step;
	logic signed [MPW-1:0] mp_add, nx_mp;
	logic [ERR_W-1:0]     nx_err;
	logic [STEPS_W-1:0]   nx_steps;
	prc_phase_t           nx_phase;
	logic                 adv_done, adv_more;

	always_comb begin
		ymaj    = sgn_q[2];
		sm_neg  = sgn_q[0];
		sn_neg  = sgn_q[1];
		mj      = ymaj ? cur_y_q : cur_x_q;
		mn      = ymaj ? cur_x_q : cur_y_q;
		mj_end  = ymaj ? end_y_q : end_x_q;
		mn_end  = ymaj ? end_x_q : end_y_q;
		sm_step = sm_neg ? -CW'(1) : CW'(1);
		sn_step = sn_neg ? -CW'(1) : CW'(1);
		mp_add  = mp_q + {{(MPW-SLW){slope_q[SLW-1]}}, slope_q};
		adv_done = 1'b0;
		adv_more = 1'b0;
		nx_phase = phase_q;
		nx_mj    = mj;
		nx_mn    = mn;
		nx_mp    = mp_q;
		nx_err   = err_q;
		nx_steps = steps_q;
		case (phase_q)
			PH_DDA: begin
				adv_done = 1'b1;
				if (steps_q != '0) begin
					adv_more = 1'b1;
					nx_steps = steps_q - 1'b1;
					nx_mj    = mj + sm_step;
					nx_mp    = mp_add;
					nx_mn    = mp_add[SLOPE_FRAC_BITS+CW-1:SLOPE_FRAC_BITS];
				end
			end
			PH_PRE: begin
				if (err_q > ERR_W'(ONE_S)) begin
					adv_done = 1'b1;
					adv_more = 1'b1;
					nx_err   = err_q - ERR_W'(ONE_S);
					nx_mn    = mn + sn_step;
				end else begin
					nx_phase = PH_MAJOR;
				end
			end
			PH_MAJOR: begin
				if (mj != mj_end) begin
					adv_done = 1'b1;
					adv_more = 1'b1;
					nx_mj    = mj + sm_step;
					nx_err   = err_q + ERR_W'($unsigned(slope_q));
					nx_phase = PH_INNER;
				end else begin
					nx_phase = PH_FIX;
				end
			end
			PH_INNER: begin
				if (mj != mj_end && err_q > ERR_W'(ONE_S)) begin
					adv_done = 1'b1;
					adv_more = 1'b1;
					nx_err   = err_q - ERR_W'(ONE_S);
					nx_mn    = mn + sn_step;
				end else begin
					nx_phase = PH_MAJOR;
				end
			end
			PH_FIX: begin
				adv_done = 1'b1;
				if (mn != mn_end) begin
					adv_more = 1'b1;
					nx_mn    = (mn < mn_end) ? mn + CW'(1) : mn - CW'(1);
				end
			end
			default: begin
				adv_done = 1'b1;
			end
		endcase
		nx_cx = ymaj ? nx_mn : nx_mj;
		nx_cy = ymaj ? nx_mj : nx_mn;
	end

	// control outputs
	logic out_free, adv_en, emit, out_we;

	always_comb begin
		out_free = !ov_q || m_tready;
		cmd_pop  = (state_q == B_IDLE) && cmd_valid && out_free;
		adv_en   = (cmd_pop && cmd.kind == K_STEP && phase_q != PH_IDLE) || (state_q == B_ADV);
		emit     = adv_en && adv_done;
		out_we   = (cmd_pop && (cmd.kind != K_STEP || phase_q == PH_IDLE)) || emit;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_pop) begin
					if (cmd.kind == K_OPEN && !s_degen) begin
						state_nx = B_DIV;
					end else if (adv_en && !adv_done) begin
						state_nx = B_ADV;
					end
				end
			end
			B_ADV: begin
				if (adv_done) begin
					state_nx = B_IDLE;
				end
			end
			B_DIV: begin
				if (cnt_q == CNT_W'(QW - 1)) begin
					state_nx = B_FIN;
				end
			end
			B_FIN: begin
				state_nx = (mode_q == MODE_THIN) ? B_IDLE : B_ERR;
			end
			B_ERR: begin
				state_nx = B_IDLE;
			end
			default: begin
				state_nx = B_IDLE;
			end
		endcase
	end

	logic [REM_W-1:0]  div_t;
	logic              div_ge;
	logic [SLW-1:0]    thin_mag;
	logic [DIST_W-1:0] bound_dist, fnsel;

	always_comb begin
		div_t      = (cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
		div_ge     = div_t >= REM_W'(am_q);
		thin_mag   = SLW'(quo_q) + SLW'(dn_neg_q && rem_q != '0);
		bound_dist = sm_neg ? {1'b0, fm_q} : DIST_W'(ONE_F) - {1'b0, fm_q};
		fnsel      = sn_neg ? DIST_W'(ONE_F) - {1'b0, fn_q} : {1'b0, fn_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			phase_q <= PH_IDLE;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (out_we) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			if (adv_en) begin
				phase_q <= (adv_done && !adv_more) ? PH_IDLE : nx_phase;
			end else if (cmd_pop && cmd.kind == K_STORE) begin
				phase_q <= PH_IDLE;
			end else if (cmd_pop && cmd.kind == K_OPEN) begin
				phase_q <= s_degen ? PH_LAST : PH_IDLE;
			end else if (state_q == B_FIN && mode_q == MODE_THIN) begin
				phase_q <= PH_DDA;
			end else if (state_q == B_ERR) begin
				phase_q <= PH_PRE;
			end
			if (cmd_pop) begin
				cnt_q <= '0;
			end else if (state_q == B_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			ovalid_q <= emit;
			ox_q     <= emit ? cur_x_q : '0;
			oy_q     <= emit ? cur_y_q : '0;
			ogrid_q  <= emit && !cur_x_q[CW-1] && !cur_y_q[CW-1]
				&& (cur_x_q[CW-2:0] < (CW-1)'(grid_columns))
				&& (cur_y_q[CW-2:0] < (CW-1)'(grid_rows));
			oend_q   <= emit && !adv_more;
		end
		if (adv_en) begin
			cur_x_q <= nx_cx;
			cur_y_q <= nx_cy;
			mp_q    <= nx_mp;
			err_q   <= nx_err;
			steps_q <= nx_steps;
		end else if (cmd_pop && cmd.kind == K_OPEN) begin
			cur_x_q   <= s_cx;
			cur_y_q   <= s_cy;
			end_x_q   <= s_ex;
			end_y_q   <= s_ey;
			sgn_q     <= s_degen ? 3'b000 : {s_ymaj, s_sn_neg, s_sm_neg};
			mode_q    <= line_mode;
			dn_neg_q  <= sdn[DW-1];
			am_q      <= s_am;
			start_n_q <= s_start_n;
			fm_q      <= s_start_m[COORD_FRAC_BITS-1:0];
			fn_q      <= s_start_n[COORD_FRAC_BITS-1:0];
			rem_q     <= REM_W'(s_an);
			quo_q     <= '0;
		end else if (state_q == B_DIV) begin
			rem_q <= div_ge ? div_t - REM_W'(am_q) : div_t;
			quo_q <= {quo_q[QW-2:0], div_ge};
		end else if (state_q == B_FIN) begin
			if (mode_q == MODE_THIN) begin
				slope_q <= dn_neg_q ? -$signed(thin_mag) : $signed(thin_mag);
				mp_q    <= {{(MPW-DW){start_n_q[DW-1]}}, start_n_q} <<< SH;
				steps_q <= am_q[DW-1:COORD_FRAC_BITS];
			end else begin
				slope_q <= $signed(SLW'(quo_q));
				prod_q  <= PROD_W'(quo_q) * PROD_W'(bound_dist);
			end
		end else if (state_q == B_ERR) begin
			err_q <= (ERR_W'(fnsel) << SH) + ERR_W'(prod_q >> COORD_FRAC_BITS);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {{(M_DATA_W-2*CELL_W){1'b0}}, oy_q[CELL_W-1:0], ox_q[CELL_W-1:0]};
	assign m_tuser  = {ogrid_q, ovalid_q};
	assign m_tlast  = oend_q;

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (cnt_q < CNT_W'(QW)))
		else $error("slope divider ran past its last quotient bit");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_we |-> (!ov_q || m_tready))
		else $error("result register overwritten while stalled");
	a_adv_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ADV) |-> (phase_q != PH_IDLE && phase_q != PH_DDA))
		else $error("walk sequencer pass in a phase that always returns");

endmodule
`default_nettype wire
